FILE: rtl/idqc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// IPv4 dotted-quad checker package
// Shared widths, types and character constants for the checker modules.
// ----------------------------------------------------------------------------
package idqc_pkg;

  localparam int CHAR_W  = 8;
  localparam int LEN_W   = 8;
  localparam int SECT_W  = 3;
  localparam int DIGIT_W = 3;
  localparam int VALUE_W = 10;

  typedef logic [CHAR_W-1:0]  char_t;
  typedef logic [LEN_W-1:0]   len_t;
  typedef logic [SECT_W-1:0]  sect_t;
  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [VALUE_W-1:0] value_t;

  localparam char_t  CHAR_TERM          = 8'h00;
  localparam char_t  CHAR_ZERO          = 8'h30;
  localparam char_t  CHAR_NINE          = 8'h39;
  localparam char_t  CHAR_DOT           = 8'h2E;
  localparam len_t   MAX_LEN_RESET      = 8'd15;
  localparam len_t   COUNT_LIMIT        = 8'd255;
  localparam value_t SECTION_MAX_VALUE  = 10'd255;
  localparam digit_t SECTION_MAX_DIGITS = 3'd3;
  localparam sect_t  SECTIONS_REQUIRED  = 3'd4;

  // Character held in the input register, handed to the scanner.
  typedef struct packed {
    logic  valid;
    char_t ch;
  } stage_t;

endpackage
`default_nettype wire

FILE: rtl/idqc_channels.sv
`default_nettype none
// ----------------------------------------------------------------------------
// IPv4 dotted-quad checker channels
// Valid/ready interfaces for the character, verdict and configuration channels.
// ----------------------------------------------------------------------------
interface idqc_char_if;
  import idqc_pkg::*;
  logic  valid;
  logic  ready;
  char_t text_char;
  modport source (output valid, output text_char, input ready);
  modport sink (input valid, input text_char, output ready);
endinterface

interface idqc_result_if;
  logic valid;
  logic ready;
  logic address_valid;
  modport source (output valid, output address_valid, input ready);
  modport sink (input valid, input address_valid, output ready);
endinterface

interface idqc_cfg_if;
  import idqc_pkg::*;
  logic valid;
  logic ready;
  len_t max_text_length;
  modport source (output valid, output max_text_length, input ready);
  modport sink (input valid, input max_text_length, output ready);
endinterface
`default_nettype wire

FILE: rtl/idqc_input_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// IPv4 dotted-quad checker input register
// Holds one accepted character until the scanner consumes it.
// ----------------------------------------------------------------------------
module idqc_input_stage (
  input  wire logic             clk,
  input  wire logic             rst,
  idqc_char_if.sink             text,
  input  wire logic             take,
  output idqc_pkg::stage_t      stage
);
  import idqc_pkg::*;

  logic  valid;
  char_t ch;

  assign text.ready = !valid || take;
  assign stage      = '{valid: valid, ch: ch};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (text.valid && text.ready) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (text.valid && text.ready) begin
      ch <= text.text_char;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/idqc_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// IPv4 dotted-quad checker scanner
// Updates the scan state for each character and registers the verdict.
// ----------------------------------------------------------------------------
module idqc_scan (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire idqc_pkg::stage_t stage,
  input  wire idqc_pkg::len_t   max_text_length,
  output logic                  take,
  idqc_result_if.source         verdict
);
  import idqc_pkg::*;

  len_t   char_count;
  sect_t  section_count;
  digit_t digit_count;
  value_t section_value;
  logic   failed;
  logic   out_valid;
  logic   address_valid;

  len_t   char_count_next;
  sect_t  section_count_next;
  digit_t digit_count_next;
  value_t section_value_next;
  logic   failed_next;
  logic   fire;
  logic   ok;
  logic   is_term;
  logic   is_digit;
  value_t digit_value;

  assign is_term     = (stage.ch == CHAR_TERM);
  assign is_digit    = (stage.ch inside {[CHAR_ZERO:CHAR_NINE]});
  assign digit_value = value_t'(stage.ch - CHAR_ZERO);
  assign take        = !is_term || !out_valid || verdict.ready;

  assign ok = !failed && (digit_count != '0) && (section_value <= SECTION_MAX_VALUE)
           && (section_count == SECTIONS_REQUIRED - 3'd1)
           && (char_count <= max_text_length);

  always_comb begin
    char_count_next    = char_count;
    section_count_next = section_count;
    digit_count_next   = digit_count;
    section_value_next = section_value;
    failed_next        = failed;
    fire               = 1'b0;
    if (stage.valid && take) begin
      if (is_term) begin
        fire               = 1'b1;
        char_count_next    = '0;
        section_count_next = '0;
        digit_count_next   = '0;
        section_value_next = '0;
        failed_next        = 1'b0;
      end else if (!failed) begin
        if (char_count == COUNT_LIMIT) begin
          failed_next = 1'b1;
        end else begin
          char_count_next = char_count + 8'd1;
          if (is_digit) begin
            if (digit_count >= SECTION_MAX_DIGITS) begin
              failed_next = 1'b1;
            end else begin
              digit_count_next   = digit_count + 3'd1;
              section_value_next = (section_value << 3) + (section_value << 1) + digit_value;
            end
          end else if (stage.ch == CHAR_DOT) begin
            if ((digit_count == '0) || (section_value > SECTION_MAX_VALUE)
                || (section_count >= SECTIONS_REQUIRED - 3'd1)) begin
              failed_next = 1'b1;
            end else begin
              section_count_next = section_count + 3'd1;
              digit_count_next   = '0;
              section_value_next = '0;
            end
          end else begin
            failed_next = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_count    <= '0;
      section_count <= '0;
      digit_count   <= '0;
      section_value <= '0;
      failed        <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      char_count    <= char_count_next;
      section_count <= section_count_next;
      digit_count   <= digit_count_next;
      section_value <= section_value_next;
      failed        <= failed_next;
      if (fire) begin
        out_valid <= 1'b1;
      end else if (verdict.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      address_valid <= ok;
    end
  end

  assign verdict.valid         = out_valid;
  assign verdict.address_valid = address_valid;

endmodule
`default_nettype wire

FILE: rtl/ipv4_dotted_quad_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// IPv4 dotted-quad checker
// Checks a zero-terminated text address, one character per transaction,
// against the dotted-decimal IPv4 form and gives one verdict per string.
//
// Characters arrive on the text channel and one verdict transaction leaves
// on the verdict channel for each zero terminator. Each character is held
// in the input register until the scanner folds it into the scan state; the
// verdict is registered when the scanner takes its terminator. A character
// is taken in every cycle, limited only by the single verdict register:
// while a verdict waits unread, a following terminator stays in the input
// register and the text channel stalls behind it, whereas other characters
// continue to flow. The cfg channel is always ready and sets the largest
// allowed text length; the user must write it only while the block is idle,
// and the block does not enforce this. Reset empties both registers, clears
// the scan state and sets the length limit to fifteen characters.
// ----------------------------------------------------------------------------
module ipv4_dotted_quad_checker (
  input  wire logic     clk,
  input  wire logic     rst,
  idqc_char_if.sink     text,
  idqc_cfg_if.sink      cfg,
  idqc_result_if.source verdict
);
  import idqc_pkg::*;

  len_t   max_text_length;
  stage_t stage;
  logic   take;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_text_length <= MAX_LEN_RESET;
    end else if (cfg.valid && cfg.ready) begin
      max_text_length <= cfg.max_text_length;
    end
  end

  idqc_input_stage u_input_stage (
    .clk   (clk),
    .rst   (rst),
    .text  (text),
    .take  (take),
    .stage (stage)
  );

  idqc_scan u_scan (
    .clk             (clk),
    .rst             (rst),
    .stage           (stage),
    .max_text_length (max_text_length),
    .take            (take),
    .verdict         (verdict)
  );

endmodule
`default_nettype wire
